// ----- hdl/tpmq_pkg.sv -----
package tpmq_pkg;

    // Table geometry, fixed by the 10-bit node and 20-bit weight ports.
    localparam int NODES       = 1024;
    localparam int LEVELS      = 10;
    localparam int WEIGHT_BITS = 20;

    // Operation codes carried in the request's operation field.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_ADEP   = 12'b000000000010,
        S_AWAIT  = 12'b000000000100,
        S_ALVL   = 12'b000000001000,
        S_AMID   = 12'b000000010000,
        S_QDEP   = 12'b000000100000,
        S_QDWAIT = 12'b000001000000,
        S_LIFT   = 12'b000010000000,
        S_LWAIT  = 12'b000100000000,
        S_DESC   = 12'b001000000000,
        S_DWAIT  = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } t_state;

endpackage

// ----- hdl/tpmq_ram.sv -----
module tpmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/tree_path_min_max_query.sv -----
// Channel  | Direction | Handshake            | Payload
// request  | in        | i_valid / o_ready    | i_operation, i_node_a, i_node_b, i_edge_weight
// result   | out       | o_valid / i_ready    | o_path_max, o_path_min, o_empty_path
//
// An add, after acceptance, does the level-0 write, then per level a read of the node's own
// entry, a read of the middle ancestor's entry and the combined write; both reads share the
// single table read port, and a root writes every level without them. A query reads both
// depths, lifts the deeper node level by level, then descends through the levels, with one
// more level-0 pass when level 0 still steps; the result then holds until taken and o_ready returns
// the cycle after. Synchronous reset idles the sequencer; tables are undefined until written.
module tree_path_min_max_query (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_operation,
    input  logic [9:0]             i_node_a,
    input  logic [9:0]             i_node_b,
    input  logic [19:0]            i_edge_weight,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [19:0]            o_path_max,
    output logic [19:0]            o_path_min,
    output logic                   o_empty_path
);

    localparam int NODES       = tpmq_pkg::NODES;
    localparam int LEVELS      = tpmq_pkg::LEVELS;
    localparam int WEIGHT_BITS = tpmq_pkg::WEIGHT_BITS;
    localparam int NB  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LB  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DB  = LEVELS;
    localparam int SD  = NODES * LEVELS;
    localparam int SB  = $clog2(SD);
    localparam int W   = WEIGHT_BITS;
    localparam int EW  = NB + 2 * W;
    localparam logic [DB-1:0] DMAX = {DB{1'b1}};
    localparam logic [W-1:0]  WMAX = {W{1'b1}};
    localparam logic [LB-1:0] LTOP = LB'(LEVELS - 1);

    tpmq_pkg::t_state r_state;

    // Working registers.
    logic [NB-1:0] r_a, r_b, r_mid;
    logic [W-1:0]  r_hi, r_lo, r_m1, r_n1;
    logic [DB-1:0] r_da, r_diff;
    logic [LB-1:0] r_k;
    logic          r_phase;
    logic          r_fin;
    logic [W-1:0]  r_w;
    logic [NB-1:0] r_pa;

    // Memories: depth per node; one packed entry (ancestor, max, min) per slot.
    logic          dep_we, ent_we;
    logic [NB-1:0] dep_waddr, dep_raddr;
    logic [DB-1:0] dep_wdata, dep_rdata;
    logic [SB-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;

    tpmq_ram #(.WIDTH(DB), .DEPTH(NODES)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_raddr(dep_raddr), .o_rdata(dep_rdata)
    );
    tpmq_ram #(.WIDTH(EW), .DEPTH(SD)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    logic [NB-1:0] e_anc;
    logic [W-1:0]  e_max, e_min;
    assign e_anc = ent_rdata[EW-1 -: NB];
    assign e_max = ent_rdata[2*W-1 -: W];
    assign e_min = ent_rdata[W-1:0];

    function automatic logic [SB-1:0] slot(input logic [NB-1:0] v, input logic [LB-1:0] k);
        logic [SB+NB-1:0] p;
        p = (SB+NB)'(v) * (SB+NB)'(LEVELS) + (SB+NB)'(k);
        return p[SB-1:0];
    endfunction

    function automatic logic [NB-1:0] wrap(input logic [9:0] x);
        logic [10:0] t;
        t = 11'(x) % 11'(NODES);
        return t[NB-1:0];
    endfunction

    logic [NB-1:0] in_a, in_b;
    assign in_a = wrap(i_node_a);
    assign in_b = wrap(i_node_b);

    assign o_ready = (r_state == tpmq_pkg::S_IDLE);

    logic [LB-1:0] k_prev;
    assign k_prev = r_k - LB'(1);

    // Write port and read address steering.
    always_comb begin
        dep_we    = 1'b0;
        dep_waddr = r_a;
        dep_wdata = (r_da >= DMAX) ? DMAX : r_da + DB'(1);
        dep_raddr = r_b;
        ent_we    = 1'b0;
        ent_waddr = slot(r_a, r_k);
        ent_wdata = {r_mid, r_m1, r_n1};
        ent_raddr = slot(r_a, k_prev);
        case (r_state)
            tpmq_pkg::S_IDLE: begin
                dep_raddr = in_b;
            end
            tpmq_pkg::S_QDEP: begin
                dep_raddr = r_a;
            end
            tpmq_pkg::S_AWAIT: begin
                dep_we = 1'b1;
                if (r_a == r_b) begin
                    dep_wdata = '0;
                end else begin
                    dep_wdata = (dep_rdata >= DMAX) ? DMAX : dep_rdata + DB'(1);
                end
                ent_we    = 1'b1;
                ent_waddr = slot(r_a, '0);
                ent_wdata = (r_a == r_b) ? {r_a, {W{1'b0}}, WMAX} : {r_b, r_w, r_w};
            end
            tpmq_pkg::S_ALVL: begin
                ent_raddr = slot(r_a, k_prev);
            end
            tpmq_pkg::S_AMID: begin
                ent_raddr = slot(r_mid, k_prev);
                // A non-root level combines its own half with the middle ancestor's half.
                if (r_a != r_b) begin
                    ent_wdata = {e_anc, (r_m1 > e_max) ? r_m1 : e_max,
                                 (r_n1 < e_min) ? r_n1 : e_min};
                end
            end
            tpmq_pkg::S_LIFT: begin
                ent_raddr = slot(r_a, r_k);
            end
            tpmq_pkg::S_DESC: begin
                ent_raddr = r_phase ? slot(r_b, r_k) : slot(r_a, r_k);
            end
            default: begin
            end
        endcase
        if (r_state == tpmq_pkg::S_AMID && r_phase) begin
            ent_we = 1'b1;
        end
    end

    // Sequencer. In S_AMID r_phase marks that the read issued last cycle has returned (a root
    // sets it at once); the add writes level k once both halves are combined.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpmq_pkg::S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                tpmq_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_a <= in_a;
                        r_b <= in_b;
                        r_w <= i_edge_weight[W-1:0];
                        r_hi <= '0;
                        r_lo <= WMAX;
                        r_phase <= 1'b0;
                        r_fin <= 1'b0;
                        if (i_operation == tpmq_pkg::OP_ADD) begin
                            r_state <= tpmq_pkg::S_AWAIT;
                        end else if (in_a == in_b) begin
                            o_path_max   <= '0;
                            o_path_min   <= '0;
                            o_empty_path <= 1'b1;
                            o_valid      <= 1'b1;
                            r_state      <= tpmq_pkg::S_OUT;
                        end else begin
                            r_state <= tpmq_pkg::S_QDEP;
                        end
                    end
                end
                tpmq_pkg::S_AWAIT: begin
                    // Level 0 written now; a root repeats it at every level.
                    r_k <= LB'(1);
                    if (r_a == r_b) begin
                        r_mid <= r_a;
                        r_m1  <= '0;
                        r_n1  <= WMAX;
                    end
                    r_state <= (LEVELS > 1) ? tpmq_pkg::S_ALVL : tpmq_pkg::S_IDLE;
                    r_phase <= 1'b0;
                end
                tpmq_pkg::S_ALVL: begin
                    if (r_a == r_b) begin
                        r_phase <= 1'b1;
                        r_state <= tpmq_pkg::S_AMID;
                    end else begin
                        r_state <= tpmq_pkg::S_ADEP;
                    end
                end
                tpmq_pkg::S_ADEP: begin
                    r_mid   <= e_anc;
                    r_m1    <= e_max;
                    r_n1    <= e_min;
                    r_phase <= 1'b0;
                    r_state <= tpmq_pkg::S_AMID;
                end
                tpmq_pkg::S_AMID: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        if (r_a != r_b) begin
                            r_mid <= e_anc;
                            r_m1  <= (r_m1 > e_max) ? r_m1 : e_max;
                            r_n1  <= (r_n1 < e_min) ? r_n1 : e_min;
                        end
                        if (r_k == LTOP) begin
                            r_state <= tpmq_pkg::S_IDLE;
                        end else begin
                            r_k     <= r_k + LB'(1);
                            r_state <= tpmq_pkg::S_ALVL;
                        end
                    end
                end
                tpmq_pkg::S_QDEP: begin
                    r_da    <= dep_rdata;
                    r_state <= tpmq_pkg::S_QDWAIT;
                end
                tpmq_pkg::S_QDWAIT: begin
                    // r_da: depth of b; dep_rdata: depth of a.
                    if (dep_rdata < r_da) begin
                        r_a    <= r_b;
                        r_b    <= r_a;
                        r_diff <= r_da - dep_rdata;
                    end else begin
                        r_diff <= dep_rdata - r_da;
                    end
                    r_k     <= '0;
                    r_state <= tpmq_pkg::S_LIFT;
                end
                tpmq_pkg::S_LIFT: begin
                    if (r_diff[0]) begin
                        r_state <= tpmq_pkg::S_LWAIT;
                    end else if (r_k == LTOP) begin
                        r_k     <= LTOP;
                        r_phase <= 1'b0;
                        r_state <= (r_a == r_b) ? tpmq_pkg::S_OUT : tpmq_pkg::S_DESC;
                        if (r_a == r_b) begin
                            o_path_max <= r_hi; o_path_min <= r_lo;
                            o_empty_path <= 1'b0; o_valid <= 1'b1;
                        end
                    end else begin
                        r_diff <= r_diff >> 1;
                        r_k    <= r_k + LB'(1);
                    end
                end
                tpmq_pkg::S_LWAIT: begin
                    if (e_max > r_hi) r_hi <= e_max;
                    if (e_min < r_lo) r_lo <= e_min;
                    r_a     <= e_anc;
                    r_diff  <= {1'b0, r_diff[DB-1:1]};
                    if (r_k == LTOP) begin
                        r_phase <= 1'b0;
                        if (e_anc == r_b) begin
                            o_path_max   <= (e_max > r_hi) ? e_max : r_hi;
                            o_path_min   <= (e_min < r_lo) ? e_min : r_lo;
                            o_empty_path <= 1'b0;
                            o_valid      <= 1'b1;
                            r_state      <= tpmq_pkg::S_OUT;
                        end else begin
                            r_state <= tpmq_pkg::S_DESC;
                        end
                    end else begin
                        r_k     <= r_k + LB'(1);
                        r_state <= tpmq_pkg::S_LIFT;
                    end
                end
                tpmq_pkg::S_DESC: begin
                    r_state <= tpmq_pkg::S_DWAIT;
                end
                tpmq_pkg::S_DWAIT: begin
                    if (!r_phase) begin
                        // Entry of a at level k; stash it and fetch b's.
                        r_pa  <= e_anc;
                        r_m1  <= e_max;
                        r_n1  <= e_min;
                        r_phase <= 1'b1;
                        r_state <= tpmq_pkg::S_DESC;
                    end else begin
                        logic          step;
                        logic [W-1:0]  hi1, lo1, hi2, lo2;
                        step = (r_pa != e_anc);
                        hi1 = (r_m1 > r_hi) ? r_m1 : r_hi;
                        lo1 = (r_n1 < r_lo) ? r_n1 : r_lo;
                        hi2 = (e_max > hi1) ? e_max : hi1;
                        lo2 = (e_min < lo1) ? e_min : lo1;
                        r_phase <= 1'b0;
                        if (r_k == '0 && (r_fin || !step)) begin
                            // The final level-0 edges of both nodes close the path.
                            o_path_max   <= hi2;
                            o_path_min   <= lo2;
                            o_empty_path <= 1'b0;
                            o_valid      <= 1'b1;
                            r_state      <= tpmq_pkg::S_OUT;
                        end else begin
                            if (step) begin
                                r_hi <= hi2;
                                r_lo <= lo2;
                                r_a  <= r_pa;
                                r_b  <= e_anc;
                            end
                            // A step at level 0 (separate trees) is followed by one
                            // more pass over the level-0 edges of the new nodes.
                            if (r_k == '0) begin
                                r_fin <= 1'b1;
                            end else begin
                                r_k <= k_prev;
                            end
                            r_state <= tpmq_pkg::S_DESC;
                        end
                    end
                end
                tpmq_pkg::S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= tpmq_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= tpmq_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/tpmq_checker.sv -----
module tpmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [19:0] o_path_max,
    input logic [19:0] o_path_min,
    input logic        o_empty_path
);

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_path_max) && $stable(o_path_min)))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_path) |-> (o_path_max == 20'd0 && o_path_min == 20'd0))
        else $error("empty path with nonzero weights");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("ready right after accept");

endmodule

bind tree_path_min_max_query tpmq_checker u_tpmq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_path_max(o_path_max),
    .o_path_min(o_path_min), .o_empty_path(o_empty_path)
);
